FILE: hw/rtl/aabb_ovp_pkg.sv
package aabb_ovp_pkg;

    // Default coordinate width: signed Q12.12 centers
    localparam int COORD_BITS_DEF = 24;

    // 0.9999 in Q0.16, rounded to nearest
    localparam logic [15:0] SHRINK_Q16 = 16'd65529;

    // Half of the full size plus the Q0.16 scale
    localparam int SHRINK_SHIFT = 17;

    // Side of box A that is touched
    typedef enum logic [1:0] {
        SIDE_RIGHT  = 2'd0,
        SIDE_LEFT   = 2'd1,
        SIDE_TOP    = 2'd2,
        SIDE_BOTTOM = 2'd3
    } side_t;

endpackage

FILE: hw/rtl/aabb_ovp_half.sv
module aabb_ovp_half #(
    parameter int COORD_BITS = aabb_ovp_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-2:0] size,
    output logic [COORD_BITS-3:0] half
);
    import aabb_ovp_pkg::*;

    localparam int ProdBits = COORD_BITS - 1 + 16;

    logic [ProdBits-1:0] prod;

    // Scale the full size by 0.9999 and halve, truncating
    assign prod = ProdBits'(size) * ProdBits'(SHRINK_Q16);
    assign half = prod[ProdBits-1:SHRINK_SHIFT];

endmodule

FILE: hw/rtl/aabb_overlap_penetration_top.sv
// Channel  | Direction | Handshake          | Beat contents
// ---------+-----------+--------------------+-------------------------------------------
// input    | in        | in_valid/in_stall  | two boxes: center, full size, enable each
// result   | out       | out_valid/out_stall| hit, contact side, two contact points, push
//
// A beat is accepted every cycle while in_stall is low; its result passes through the input
// register, the shrink-multiply register and the result register before it is presented.
// Each of the three stages advances on its own, so a held result does not stop input
// beats until all three stages are full; in_stall then follows out_stall.
// rst_n clears the stage valid bits only; payload registers are not reset.
module aabb_overlap_penetration_top #(
    parameter int COORD_BITS = aabb_ovp_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] first_center_x,
    input  logic signed [COORD_BITS-1:0] first_center_y,
    input  logic        [COORD_BITS-2:0] first_width,
    input  logic        [COORD_BITS-2:0] first_height,
    input  logic                         first_enabled,
    input  logic signed [COORD_BITS-1:0] second_center_x,
    input  logic signed [COORD_BITS-1:0] second_center_y,
    input  logic        [COORD_BITS-2:0] second_width,
    input  logic        [COORD_BITS-2:0] second_height,
    input  logic                         second_enabled,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic        [1:0]            contact_side,
    output logic signed [COORD_BITS+1:0] first_contact_x,
    output logic signed [COORD_BITS+1:0] first_contact_y,
    output logic signed [COORD_BITS+1:0] second_contact_x,
    output logic signed [COORD_BITS+1:0] second_contact_y,
    output logic signed [COORD_BITS+1:0] push_x,
    output logic signed [COORD_BITS+1:0] push_y
);
    import aabb_ovp_pkg::*;

    localparam int W  = COORD_BITS + 2;
    localparam int HB = COORD_BITS - 2;

    // Stage valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !v3_reg || !out_stall;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // Stage 1: capture the input beat
    logic signed [COORD_BITS-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic        [COORD_BITS-2:0] aw1_reg, ah1_reg, bw1_reg, bh1_reg;
    logic                         en1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ax1_reg <= first_center_x;
            ay1_reg <= first_center_y;
            aw1_reg <= first_width;
            ah1_reg <= first_height;
            bx1_reg <= second_center_x;
            by1_reg <= second_center_y;
            bw1_reg <= second_width;
            bh1_reg <= second_height;
            en1_reg <= first_enabled && second_enabled;
        end
    end

    // Shrunk half-sizes
    logic [HB-1:0] ahw_next, ahh_next, bhw_next, bhh_next;

    aabb_ovp_half #(.COORD_BITS(COORD_BITS)) u_half_aw (.size(aw1_reg), .half(ahw_next));
    aabb_ovp_half #(.COORD_BITS(COORD_BITS)) u_half_ah (.size(ah1_reg), .half(ahh_next));
    aabb_ovp_half #(.COORD_BITS(COORD_BITS)) u_half_bw (.size(bw1_reg), .half(bhw_next));
    aabb_ovp_half #(.COORD_BITS(COORD_BITS)) u_half_bh (.size(bh1_reg), .half(bhh_next));

    // Stage 2: hold centers and halves
    logic signed [COORD_BITS-1:0] ax2_reg, ay2_reg, bx2_reg, by2_reg;
    logic        [HB-1:0]         ahw_reg, ahh_reg, bhw_reg, bhh_reg;
    logic                         en2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            bx2_reg <= bx1_reg;
            by2_reg <= by1_reg;
            ahw_reg <= ahw_next;
            ahh_reg <= ahh_next;
            bhw_reg <= bhw_next;
            bhh_reg <= bhh_next;
            en2_reg <= en1_reg;
        end
    end

    // Corners, edge depths, overlap test
    logic signed [W-1:0] ax_e, ay_e, bx_e, by_e;
    logic signed [W-1:0] a_l, a_r, a_b, a_t, b_l, b_r, b_b, b_t;
    logic signed [W-1:0] d_right, d_left, d_top, d_bottom;
    logic        [W-2:0] m_right, m_left, m_top, m_bottom;
    logic                ov_x, ov_y, hit_c;

    assign ax_e = {{2{ax2_reg[COORD_BITS-1]}}, ax2_reg};
    assign ay_e = {{2{ay2_reg[COORD_BITS-1]}}, ay2_reg};
    assign bx_e = {{2{bx2_reg[COORD_BITS-1]}}, bx2_reg};
    assign by_e = {{2{by2_reg[COORD_BITS-1]}}, by2_reg};

    assign a_l = ax_e - $signed({4'b0, ahw_reg});
    assign a_r = ax_e + $signed({4'b0, ahw_reg});
    assign a_b = ay_e - $signed({4'b0, ahh_reg});
    assign a_t = ay_e + $signed({4'b0, ahh_reg});
    assign b_l = bx_e - $signed({4'b0, bhw_reg});
    assign b_r = bx_e + $signed({4'b0, bhw_reg});
    assign b_b = by_e - $signed({4'b0, bhh_reg});
    assign b_t = by_e + $signed({4'b0, bhh_reg});

    assign d_right  = a_r - b_l;
    assign d_left   = a_l - b_r;
    assign d_top    = a_t - b_b;
    assign d_bottom = a_b - b_t;

    // Magnitudes stay below 2^(COORD_BITS+1)
    assign m_right  = d_right[W-1]  ? (W-1)'(-d_right)  : d_right[W-2:0];
    assign m_left   = d_left[W-1]   ? (W-1)'(-d_left)   : d_left[W-2:0];
    assign m_top    = d_top[W-1]    ? (W-1)'(-d_top)    : d_top[W-2:0];
    assign m_bottom = d_bottom[W-1] ? (W-1)'(-d_bottom) : d_bottom[W-2:0];

    assign ov_x  = d_right[W-1] != d_left[W-1];
    assign ov_y  = d_top[W-1] != d_bottom[W-1];
    assign hit_c = en2_reg && ov_x && ov_y;

    // Pick the shallowest side; ties keep the lower code
    side_t         side_c;
    logic [W-2:0]  min_c;

    always_comb
    begin
        side_c = SIDE_RIGHT;
        min_c  = m_right;
        if (m_left < min_c)
        begin
            side_c = SIDE_LEFT;
            min_c  = m_left;
        end
        if (m_top < min_c)
        begin
            side_c = SIDE_TOP;
            min_c  = m_top;
        end
        if (m_bottom < min_c)
        begin
            side_c = SIDE_BOTTOM;
            min_c  = m_bottom;
        end
    end

    // Result fields by side; all zero on a miss
    logic                hit_next;
    logic [1:0]          side_next;
    logic signed [W-1:0] pax_next, pay_next, pbx_next, pby_next, dx_next, dy_next;

    always_comb
    begin
        hit_next  = hit_c;
        side_next = 2'b00;
        pax_next  = '0;
        pay_next  = '0;
        pbx_next  = '0;
        pby_next  = '0;
        dx_next   = '0;
        dy_next   = '0;
        if (hit_c)
        begin
            side_next = side_c;
            case (side_c)
                SIDE_RIGHT:
                begin
                    pax_next = a_r;
                    pay_next = ay_e;
                    pbx_next = b_l;
                    pby_next = by_e;
                    dx_next  = -$signed({1'b0, min_c});
                end
                SIDE_LEFT:
                begin
                    pax_next = a_l;
                    pay_next = ay_e;
                    pbx_next = b_r;
                    pby_next = by_e;
                    dx_next  = $signed({1'b0, min_c});
                end
                SIDE_TOP:
                begin
                    pax_next = ax_e;
                    pay_next = a_t;
                    pbx_next = bx_e;
                    pby_next = b_b;
                    dy_next  = -$signed({1'b0, min_c});
                end
                default:
                begin
                    pax_next = ax_e;
                    pay_next = a_b;
                    pbx_next = bx_e;
                    pby_next = b_t;
                    dy_next  = $signed({1'b0, min_c});
                end
            endcase
        end
    end

    // Stage 3: result register, held while stalled
    logic                hit_reg;
    logic [1:0]          side_reg;
    logic signed [W-1:0] pax_reg, pay_reg, pbx_reg, pby_reg, dx_reg, dy_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            hit_reg  <= hit_next;
            side_reg <= side_next;
            pax_reg  <= pax_next;
            pay_reg  <= pay_next;
            pbx_reg  <= pbx_next;
            pby_reg  <= pby_next;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
        end
    end

    assign out_valid        = v3_reg;
    assign hit              = hit_reg;
    assign contact_side     = side_reg;
    assign first_contact_x  = pax_reg;
    assign first_contact_y  = pay_reg;
    assign second_contact_x = pbx_reg;
    assign second_contact_y = pby_reg;
    assign push_x           = dx_reg;
    assign push_y           = dy_reg;

    // A miss carries a zero side, zero push and zero first_contact_x and second_contact_y
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> contact_side == 2'b00 && push_x == '0 && push_y == '0
            && first_contact_x == '0 && second_contact_y == '0)
        else $error("miss result not cleared");

    // Horizontal sides push only along x
    a_push_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit && (contact_side == SIDE_RIGHT || contact_side == SIDE_LEFT)
            |-> push_y == '0)
        else $error("horizontal contact with vertical push");

    // Right contact pushes A toward negative x
    a_push_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit && contact_side == SIDE_RIGHT |-> push_x <= 0)
        else $error("right contact push has wrong sign");

    // Input backs up only when every stage is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && out_stall)
        else $error("input stalled with a free stage");

endmodule

FILE: test/testbench.sv
module testbench;
    import aabb_ovp_pkg::*;

    localparam int CW = COORD_BITS_DEF;   // center width
    localparam int SW = CW - 1;           // size width
    localparam int OW = CW + 2;           // result coordinate width
    localparam int Q = 4096;              // one unit in Q12.12
    localparam int IDLE_PCT = 37;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS = 10;
    localparam longint TIMEOUT_UNITS = 4_000_000;

    typedef struct {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic        [SW-1:0] aw;
        logic        [SW-1:0] ah;
        logic                 aen;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic        [SW-1:0] bw;
        logic        [SW-1:0] bh;
        logic                 ben;
    } box_pair_t;

    typedef struct {
        logic                 hit;
        side_t                side;
        logic signed [OW-1:0] pax;
        logic signed [OW-1:0] pay;
        logic signed [OW-1:0] pbx;
        logic signed [OW-1:0] pby;
        logic signed [OW-1:0] dx;
        logic signed [OW-1:0] dy;
    } contact_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [CW-1:0] first_center_x;
    logic signed [CW-1:0] first_center_y;
    logic        [SW-1:0] first_width;
    logic        [SW-1:0] first_height;
    logic                 first_enabled;
    logic signed [CW-1:0] second_center_x;
    logic signed [CW-1:0] second_center_y;
    logic        [SW-1:0] second_width;
    logic        [SW-1:0] second_height;
    logic                 second_enabled;
    logic                 out_valid;
    logic                 out_stall;
    logic                 hit;
    logic        [1:0]    contact_side;
    logic signed [OW-1:0] first_contact_x;
    logic signed [OW-1:0] first_contact_y;
    logic signed [OW-1:0] second_contact_x;
    logic signed [OW-1:0] second_contact_y;
    logic signed [OW-1:0] push_x;
    logic signed [OW-1:0] push_y;

    contact_t expected_contacts [$];
    int       mismatch_count;
    bit       tx_gaps;
    bit       rx_gaps;
    bit       hold_req;
    bit       hold_ack;

    aabb_overlap_penetration_top #(
        .COORD_BITS (CW)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .first_center_x   (first_center_x),
        .first_center_y   (first_center_y),
        .first_width      (first_width),
        .first_height     (first_height),
        .first_enabled    (first_enabled),
        .second_center_x  (second_center_x),
        .second_center_y  (second_center_y),
        .second_width     (second_width),
        .second_height    (second_height),
        .second_enabled   (second_enabled),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .hit              (hit),
        .contact_side     (contact_side),
        .first_contact_x  (first_contact_x),
        .first_contact_y  (first_contact_y),
        .second_contact_x (second_contact_x),
        .second_contact_y (second_contact_y),
        .push_x           (push_x),
        .push_y           (push_y)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_UNITS);
        $display("Simulation FAILED");
        $finish;
    end

    // Half-size shrunk by 0.9999, truncated
    function automatic longint half_extent(logic [SW-1:0] size);
        return (longint'(size) * longint'(SHRINK_Q16)) >>> SHRINK_SHIFT;
    endfunction

    // Work out the contact for one box pair
    function automatic contact_t predict_contact(box_pair_t p);
        longint ax, ay, bx, by;
        longint a_l, a_r, a_b, a_t, b_l, b_r, b_b, b_t;
        longint depth [4];
        longint mag [4];
        longint pax, pay, pbx, pby, dx, dy;
        bit     ovx, ovy;
        int     best;
        int     k;
        contact_t r;
        ax = longint'(p.ax);
        ay = longint'(p.ay);
        bx = longint'(p.bx);
        by = longint'(p.by);
        a_l = ax - half_extent(p.aw);
        a_r = ax + half_extent(p.aw);
        a_b = ay - half_extent(p.ah);
        a_t = ay + half_extent(p.ah);
        b_l = bx - half_extent(p.bw);
        b_r = bx + half_extent(p.bw);
        b_b = by - half_extent(p.bh);
        b_t = by + half_extent(p.bh);
        depth[0] = a_r - b_l;
        depth[1] = a_l - b_r;
        depth[2] = a_t - b_b;
        depth[3] = a_b - b_t;
        // a zero depth counts as non-negative
        ovx = (depth[0] < 0) != (depth[1] < 0);
        ovy = (depth[2] < 0) != (depth[3] < 0);

        r.hit  = 1'b0;
        r.side = SIDE_RIGHT;
        r.pax  = '0;
        r.pay  = '0;
        r.pbx  = '0;
        r.pby  = '0;
        r.dx   = '0;
        r.dy   = '0;
        if (!(p.aen && p.ben && ovx && ovy))
            return r;

        // smallest absolute depth wins, lowest side on a tie
        for (k = 0; k < 4; k++)
            mag[k] = (depth[k] < 0) ? -depth[k] : depth[k];
        best = 0;
        for (k = 1; k < 4; k++)
            if (mag[k] < mag[best])
                best = k;

        r.hit  = 1'b1;
        r.side = side_t'(best[1:0]);
        dx = 0;
        dy = 0;
        case (r.side)
            SIDE_RIGHT:
            begin
                pax = a_r; pay = ay; pbx = b_l; pby = by; dx = -mag[0];
            end
            SIDE_LEFT:
            begin
                pax = a_l; pay = ay; pbx = b_r; pby = by; dx = mag[1];
            end
            SIDE_TOP:
            begin
                pax = ax; pay = a_t; pbx = bx; pby = b_b; dy = -mag[2];
            end
            default:
            begin
                pax = ax; pay = a_b; pbx = bx; pby = b_t; dy = mag[3];
            end
        endcase
        r.pax = pax[OW-1:0];
        r.pay = pay[OW-1:0];
        r.pbx = pbx[OW-1:0];
        r.pby = pby[OW-1:0];
        r.dx  = dx[OW-1:0];
        r.dy  = dy[OW-1:0];
        return r;
    endfunction

    function automatic box_pair_t make_pair(int ax, int ay, int aw, int ah, bit aen,
                                            int bx, int by, int bw, int bh, bit ben);
        box_pair_t p;
        p.ax = CW'(ax);
        p.ay = CW'(ay);
        p.aw = SW'(aw);
        p.ah = SW'(ah);
        p.aen = aen;
        p.bx = CW'(bx);
        p.by = CW'(by);
        p.bw = SW'(bw);
        p.bh = SW'(bh);
        p.ben = ben;
        return p;
    endfunction

    // Mostly nearby boxes of similar size, some large boxes, some noise
    function automatic box_pair_t random_pair();
        box_pair_t p;
        int kind;
        int span;
        int off_x;
        int off_y;
        kind = $urandom_range(99);
        p.ax = CW'($urandom);
        p.ay = CW'($urandom);
        p.aw = SW'($urandom);
        p.ah = SW'($urandom);
        p.aen = $urandom_range(1);
        p.bx = CW'($urandom);
        p.by = CW'($urandom);
        p.bw = SW'($urandom);
        p.bh = SW'($urandom);
        p.ben = $urandom_range(1);
        if (kind < 70)
        begin
            span = 1 << $urandom_range(20, 4);
            off_x = int'($urandom_range(2 * span)) - span;
            off_y = int'($urandom_range(2 * span)) - span;
            p.aw = SW'($urandom_range(span));
            p.ah = SW'($urandom_range(span));
            p.bw = SW'($urandom_range(span));
            p.bh = SW'($urandom_range(span));
            p.bx = p.ax + CW'(off_x);
            p.by = p.ay + CW'(off_y);
            p.aen = $urandom_range(99) < 95;
            p.ben = $urandom_range(99) < 95;
        end
        else if (kind < 85)
        begin
            p.aen = 1'b1;
            p.ben = 1'b1;
        end
        return p;
    endfunction

    // Offer one beat and record its expected result on acceptance
    task automatic offer_pair(box_pair_t p);
        while (tx_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        first_center_x  <= p.ax;
        first_center_y  <= p.ay;
        first_width     <= p.aw;
        first_height    <= p.ah;
        first_enabled   <= p.aen;
        second_center_x <= p.bx;
        second_center_y <= p.by;
        second_width    <= p.bw;
        second_height   <= p.bh;
        second_enabled  <= p.ben;
        do
            @(posedge clk);
        while (in_stall);
        expected_contacts.push_back(predict_contact(p));
        @(negedge clk);
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_contacts.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_special_cases();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        // all zero, then zero-size boxes apart
        offer_pair(make_pair(0, 0, 0, 0, 1, 0, 0, 0, 0, 1));
        offer_pair(make_pair(0, 0, 0, 0, 1, Q, Q, 0, 0, 1));
        // identical boxes: four-way tie, then top/bottom tie
        offer_pair(make_pair(0, 0, 2*Q, 2*Q, 1, 0, 0, 2*Q, 2*Q, 1));
        offer_pair(make_pair(Q, -Q, 4*Q, 2*Q, 1, Q, -Q, 4*Q, 2*Q, 1));
        // each side in turn
        offer_pair(make_pair(0, 0, 4*Q, 4*Q, 1, 3*Q, 0, 4*Q, 4*Q, 1));
        offer_pair(make_pair(0, 0, 4*Q, 4*Q, 1, -3*Q, 0, 4*Q, 4*Q, 1));
        offer_pair(make_pair(0, 0, 4*Q, 4*Q, 1, 0, 3*Q, 4*Q, 4*Q, 1));
        offer_pair(make_pair(0, 0, 4*Q, 4*Q, 1, 0, -3*Q, 4*Q, 4*Q, 1));
        // edges that touch before shrinking do not hit
        offer_pair(make_pair(0, 0, 2*Q, 2*Q, 1, 2*Q, 0, 2*Q, 2*Q, 1));
        offer_pair(make_pair(0, 0, 2*Q, 2*Q, 1, 0, 2*Q, 2*Q, 2*Q, 1));
        // shrunk edges meeting exactly: zero depth on each side
        offer_pair(make_pair(0, 0, 2*Q, 2*Q, 1, 8190, 0, 2*Q, 2*Q, 1));
        offer_pair(make_pair(0, 0, 2*Q, 2*Q, 1, -8190, 0, 2*Q, 2*Q, 1));
        offer_pair(make_pair(0, 0, 2*Q, 2*Q, 1, 0, 8190, 2*Q, 2*Q, 1));
        offer_pair(make_pair(0, 0, 2*Q, 2*Q, 1, 0, -8190, 2*Q, 2*Q, 1));
        // disabled boxes over an overlap
        offer_pair(make_pair(0, 0, 4*Q, 4*Q, 0, Q, 0, 4*Q, 4*Q, 1));
        offer_pair(make_pair(0, 0, 4*Q, 4*Q, 1, Q, 0, 4*Q, 4*Q, 0));
        offer_pair(make_pair(0, 0, 4*Q, 4*Q, 0, Q, 0, 4*Q, 4*Q, 0));
        // field extremes
        offer_pair(make_pair(8388607, 8388607, 8388607, 8388607, 1,
                             -8388608, -8388608, 8388607, 8388607, 1));
        offer_pair(make_pair(-8388608, -8388608, 8388607, 8388607, 1,
                             8388607, 8388607, 8388607, 8388607, 1));
        offer_pair(make_pair(8388607, 8388607, 8388607, 8388607, 1,
                             8388607, 8388607, 8388607, 8388607, 1));
        offer_pair(make_pair(-8388608, -8388608, 2*Q, 2*Q, 1,
                             -8388608 + Q, -8388608, 2*Q, 2*Q, 1));
        offer_pair(make_pair(-1, -1, 8388607, 8388607, 1, -1, -1, 8388607, 0, 1));
        offer_pair(make_pair(0, 0, 8388607, 0, 1, 0, 0, 8388607, 0, 1));
    endtask

    task automatic test_random_pairs(int count, bit gaps);
        int n;
        tx_gaps = gaps;
        rx_gaps = gaps;
        for (n = 0; n < count; n++)
            offer_pair(random_pair());
    endtask

    // Long output hold while beats keep coming, so the pipe fills and stalls
    task automatic test_output_hold();
        int n;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        hold_req = ~hold_req;
        for (n = 0; n < 40; n++)
            offer_pair(random_pair());
    endtask

    // Pause the sender until the pipe is empty, then resume
    task automatic test_drain_pause();
        int n;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        for (n = 0; n < 20; n++)
            offer_pair(random_pair());
        wait_results_drained();
        for (n = 0; n < 20; n++)
            offer_pair(random_pair());
    endtask

    // Receiver: random stall, or a long counted hold on request
    initial
    begin : receiver
        int held;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_ack)
            begin
                out_stall <= 1'b1;
                for (held = 1; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                hold_ack = hold_req;
            end
            else
                out_stall <= rx_gaps && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic report_contact_error(string why, contact_t want, contact_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%s", why);
            $display("  expected hit=%0d side=%0d a=(%0d,%0d) b=(%0d,%0d) push=(%0d,%0d)",
                     want.hit, want.side, want.pax, want.pay, want.pbx, want.pby,
                     want.dx, want.dy);
            $display("  actual   hit=%0d side=%0d a=(%0d,%0d) b=(%0d,%0d) push=(%0d,%0d)",
                     got.hit, got.side, got.pax, got.pay, got.pbx, got.pby,
                     got.dx, got.dy);
        end
    endtask

    // Compare each accepted result beat with the oldest expectation
    always @(posedge clk)
    begin
        contact_t got;
        contact_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.hit  = hit;
            got.side = side_t'(contact_side);
            got.pax  = first_contact_x;
            got.pay  = first_contact_y;
            got.pbx  = second_contact_x;
            got.pby  = second_contact_y;
            got.dx   = push_x;
            got.dy   = push_y;
            if (expected_contacts.size() == 0)
            begin
                want = got;
                report_contact_error("result beat with nothing expected", want, got);
            end
            else
            begin
                want = expected_contacts.pop_front();
                if (got.hit !== want.hit || got.side !== want.side ||
                    got.pax !== want.pax || got.pay !== want.pay ||
                    got.pbx !== want.pbx || got.pby !== want.pby ||
                    got.dx !== want.dx || got.dy !== want.dy)
                    report_contact_error("contact mismatch", want, got);
            end
        end
    end

    // Reset, run each test in turn, then drain and judge
    initial
    begin
        mismatch_count  = 0;
        tx_gaps         = 1'b0;
        rx_gaps         = 1'b0;
        hold_req        = 1'b0;
        hold_ack        = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        first_center_x  = '0;
        first_center_y  = '0;
        first_width     = '0;
        first_height    = '0;
        first_enabled   = 1'b0;
        second_center_x = '0;
        second_center_y = '0;
        second_width    = '0;
        second_height   = '0;
        second_enabled  = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_special_cases();
        test_random_pairs(200, 1'b1);
        test_random_pairs(80, 1'b0);
        test_output_hold();
        test_drain_pause();
        test_random_pairs(60, 1'b1);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/aabb_ovp_pkg.sv
hw/rtl/aabb_ovp_half.sv
hw/rtl/aabb_overlap_penetration_top.sv
test/testbench.sv
